// ===== hdl/rsrf_pkg.sv =====
`timescale 1ns / 1ps

package rsrf_pkg;

    // Default geometry of the ring.
    localparam int SLOT_BYTES_DEF = 64;
    localparam int NUM_SLOTS_DEF  = 16;

    // Fixed field widths.
    localparam int LEN_W      = 7;
    localparam int SLOTCNT_W  = 5;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 2;

    // Request types.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_CLEARED = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT   = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [LEN_W-1:0]     RECORD_BYTES_RST = 7'd64;
    localparam logic [SLOTCNT_W-1:0] SLOT_COUNT_RST   = 5'd16;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [7:0]       data_byte;
        logic             last_byte;
        logic [LEN_W-1:0] read_len;
    } t_req;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             has_data;
        logic             out_last;
        logic [LEN_W-1:0] count;
        logic [1:0]       status;
        logic             is_empty;
        logic             is_full;
    } t_result;

endpackage

// ===== hdl/rsrf_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module rsrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/record_slot_ring_fifo.sv =====
`timescale 1ns / 1ps

// Ring of fixed-size record slots. Each request is taken at a rising edge where i_start is
// high and o_busy is low; results appear one per cycle on o_result, marked by o_strobe, and
// cannot be held off, so the receiver must take every strobed result in the cycle it shows.
// Write, clear and rejected-read requests never raise o_busy: while no read holds o_busy,
// one such request can be taken every cycle, and its single result is registered and
// shows in the cycle after acceptance. A read that returns bytes keeps o_busy high while
// it fetches the stored length from the length memory, issues one data memory read per
// byte, and lets the last byte leave the data memory's output register; the bytes follow
// back to back. A read that returns no bytes holds o_busy only while its length is fetched.
// Record bytes live in a data memory of NUM_SLOTS slots padded to a power-of-two stride;
// stored lengths live in a second memory shadowed by one valid bit per slot, so reset and
// clear take effect at once and no clearing pass is needed. The user writes configuration
// only while the block is idle; the block itself does not enforce this.
module record_slot_ring_fifo
    import rsrf_pkg::*;
#(
    parameter int SLOT_BYTES = SLOT_BYTES_DEF,
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_req                 i_req,
    output logic                 o_busy,
    output logic                 o_strobe,
    output t_result              o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Byte offset bits within a slot, slot index bits, and a width wide enough to compare
    // slot numbers against the slot count register.
    localparam int AW    = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int SW    = $clog2(NUM_SLOTS);
    localparam int SCW   = $clog2(NUM_SLOTS + 1);
    localparam int CMPW  = (SCW > SLOTCNT_W) ? SCW : SLOTCNT_W;
    localparam int DDEPTH = NUM_SLOTS * (2 ** AW);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LEN  = 4'b0010,
        S_READ = 4'b0100,
        S_TAIL = 4'b1000
    } t_state;

    // Configuration.
    logic [LEN_W-1:0]     r_record_bytes;
    logic [SLOTCNT_W-1:0] r_slot_count;

    // Ring state.
    logic [SW-1:0]        r_head, n_head;
    logic [SW-1:0]        r_tail, n_tail;
    logic                 r_full, n_full;
    logic [LEN_W-1:0]     r_partial, n_partial;
    logic                 r_drop, n_drop;
    logic [NUM_SLOTS-1:0] r_len_vld, n_len_vld;

    // Read sequencer.
    t_state               r_state, n_state;
    logic [SW-1:0]        r_slot, n_slot;
    logic                 r_rd_vld, n_rd_vld;
    logic [LEN_W-1:0]     r_want, n_want;
    logic [LEN_W-1:0]     r_n, n_n;
    logic [LEN_W-1:0]     r_idx, n_idx;
    logic                 r_pend, n_pend;
    logic                 r_pend_last, n_pend_last;

    // Result register.
    logic                 r_strobe, n_strobe;
    t_result              r_result, n_result;

    // Memory ports.
    logic                 dmem_we;
    logic [SW+AW-1:0]     dmem_waddr;
    logic [SW+AW-1:0]     dmem_raddr;
    logic [7:0]           dmem_rdata;
    logic                 lmem_we;
    logic [LEN_W-1:0]     lmem_wdata;
    logic [LEN_W-1:0]     lmem_rdata;

    logic                 accept;
    logic [LEN_W-1:0]     eff_bytes;
    logic [CMPW-1:0]      eff_slots;
    logic                 ring_empty;
    logic                 drop_now;
    logic [LEN_W-1:0]     wr_cnt;
    logic [LEN_W-1:0]     stored_len;
    logic [LEN_W-1:0]     rd_n;

    // Next slot index around a ring of eff_slots entries; any index at or past the count
    // wraps to slot zero.
    function automatic logic [SW-1:0] next_index(input logic [SW-1:0] idx,
                                                 input logic [CMPW-1:0] slots);
        logic [CMPW-1:0] nxt;
        nxt = CMPW'(idx) + CMPW'(1);
        return (nxt >= slots) ? '0 : nxt[SW-1:0];
    endfunction

    assign accept = i_start && !o_busy;

    // Register values outside their legal range saturate when used.
    always_comb begin
        if (r_record_bytes == '0) begin
            eff_bytes = LEN_W'(1);
        end else if (r_record_bytes > LEN_W'(SLOT_BYTES)) begin
            eff_bytes = LEN_W'(SLOT_BYTES);
        end else begin
            eff_bytes = r_record_bytes;
        end
        if (r_slot_count == '0) begin
            eff_slots = CMPW'(1);
        end else if (CMPW'(r_slot_count) > CMPW'(NUM_SLOTS)) begin
            eff_slots = CMPW'(NUM_SLOTS);
        end else begin
            eff_slots = CMPW'(r_slot_count);
        end
    end

    assign ring_empty = !r_full && (r_head == r_tail);

    // A record is dropped only when its first byte finds the ring full.
    assign drop_now = (r_partial == '0) && !r_drop && r_full;

    // A slot whose valid bit is clear holds no record and reads as length zero.
    assign stored_len = r_rd_vld ? lmem_rdata : '0;
    assign rd_n       = (r_want < stored_len) ? r_want : stored_len;

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_full      = r_full;
        n_partial   = r_partial;
        n_drop      = r_drop;
        n_len_vld   = r_len_vld;
        n_state     = r_state;
        n_slot      = r_slot;
        n_rd_vld    = r_rd_vld;
        n_want      = r_want;
        n_n         = r_n;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        n_strobe    = 1'b0;
        n_result    = r_result;
        dmem_we     = 1'b0;
        dmem_waddr  = {r_head, r_partial[AW-1:0]};
        dmem_raddr  = {r_slot, r_idx[AW-1:0]};
        lmem_we     = 1'b0;
        lmem_wdata  = r_partial;
        wr_cnt      = r_partial;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req.req_type)
                        REQ_WRITE: begin
                            n_strobe          = 1'b1;
                            n_result.out_byte = '0;
                            n_result.has_data = 1'b0;
                            n_result.out_last = 1'b1;
                            if (r_drop || drop_now) begin
                                n_drop          = !i_req.last_byte;
                                n_result.count  = '0;
                                n_result.status = ST_DROPPED;
                            end else begin
                                if (r_partial < eff_bytes) begin
                                    dmem_we = 1'b1;
                                    wr_cnt  = r_partial + LEN_W'(1);
                                end
                                n_partial       = wr_cnt;
                                n_result.count  = wr_cnt;
                                n_result.status = ST_OK;
                                if (i_req.last_byte) begin
                                    lmem_we           = 1'b1;
                                    lmem_wdata        = wr_cnt;
                                    n_len_vld[r_head] = 1'b1;
                                    n_partial         = '0;
                                    n_head            = next_index(r_head, eff_slots);
                                    if (n_head == r_tail) begin
                                        n_full = 1'b1;
                                    end
                                end
                            end
                            n_result.is_empty = !n_full && (n_head == n_tail);
                            n_result.is_full  = n_full;
                        end
                        REQ_READ: begin
                            if (ring_empty) begin
                                n_strobe          = 1'b1;
                                n_result.out_byte = '0;
                                n_result.has_data = 1'b0;
                                n_result.out_last = 1'b1;
                                n_result.count    = '0;
                                n_result.status   = ST_EMPTY;
                                n_result.is_empty = 1'b1;
                                n_result.is_full  = r_full;
                            end else begin
                                // Free the slot now; the length memory is addressed by the
                                // tail and its data shows in the next cycle.
                                n_slot            = r_tail;
                                n_rd_vld          = r_len_vld[r_tail];
                                n_len_vld[r_tail] = 1'b0;
                                n_tail            = next_index(r_tail, eff_slots);
                                n_full            = 1'b0;
                                n_want            = i_req.read_len;
                                n_state           = S_LEN;
                            end
                        end
                        REQ_CLEAR: begin
                            n_len_vld         = '0;
                            n_head            = '0;
                            n_tail            = '0;
                            n_full            = 1'b0;
                            n_partial         = '0;
                            n_drop            = 1'b0;
                            n_strobe          = 1'b1;
                            n_result.out_byte = '0;
                            n_result.has_data = 1'b0;
                            n_result.out_last = 1'b1;
                            n_result.count    = '0;
                            n_result.status   = ST_CLEARED;
                            n_result.is_empty = 1'b1;
                            n_result.is_full  = 1'b0;
                        end
                        default: begin
                            // Unknown request types are taken and ignored.
                        end
                    endcase
                end
            end
            S_LEN: begin
                if (rd_n == '0) begin
                    n_strobe          = 1'b1;
                    n_result.out_byte = '0;
                    n_result.has_data = 1'b0;
                    n_result.out_last = 1'b1;
                    n_result.count    = '0;
                    n_result.status   = ST_OK;
                    n_result.is_empty = ring_empty;
                    n_result.is_full  = r_full;
                    n_state           = S_IDLE;
                end else begin
                    n_n     = rd_n;
                    n_idx   = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_pend      = 1'b1;
                n_pend_last = (r_idx + LEN_W'(1)) == r_n;
                n_idx       = r_idx + LEN_W'(1);
                if ((r_idx + LEN_W'(1)) == r_n) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A byte fetched in the previous cycle leaves the data memory now.
        if (r_pend) begin
            n_strobe          = 1'b1;
            n_result.out_byte = dmem_rdata;
            n_result.has_data = 1'b1;
            n_result.out_last = r_pend_last;
            n_result.count    = r_n;
            n_result.status   = ST_OK;
            n_result.is_empty = ring_empty;
            n_result.is_full  = r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_bytes <= RECORD_BYTES_RST;
            r_slot_count   <= SLOT_COUNT_RST;
            r_head         <= '0;
            r_tail         <= '0;
            r_full         <= 1'b0;
            r_partial      <= '0;
            r_drop         <= 1'b0;
            r_len_vld      <= '0;
            r_state        <= S_IDLE;
            r_pend         <= 1'b0;
            r_strobe       <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_RECORD_BYTES)) begin
                r_record_bytes <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == CFG_SLOT_COUNT)) begin
                r_slot_count <= i_cfg_data[SLOTCNT_W-1:0];
            end
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_full    <= n_full;
            r_partial <= n_partial;
            r_drop    <= n_drop;
            r_len_vld <= n_len_vld;
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot      <= n_slot;
        r_rd_vld    <= n_rd_vld;
        r_want      <= n_want;
        r_n         <= n_n;
        r_idx       <= n_idx;
        r_pend_last <= n_pend_last;
        r_result    <= n_result;
    end

    rsrf_ram #(
        .WIDTH (8),
        .DEPTH (DDEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (dmem_we),
        .i_waddr (dmem_waddr),
        .i_wdata (i_req.data_byte),
        .i_raddr (dmem_raddr),
        .o_rdata (dmem_rdata)
    );

    rsrf_ram #(
        .WIDTH (LEN_W),
        .DEPTH (NUM_SLOTS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (lmem_we),
        .i_waddr (r_head),
        .i_wdata (lmem_wdata),
        .i_raddr (r_tail),
        .o_rdata (lmem_rdata)
    );

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // The ring is only full when the head has caught up with the tail.
    a_full_meets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_head == r_tail))
        else $error("full flag set with head and tail apart");

    // A fetched data byte is only in flight while a read is streaming.
    a_pend_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_READ || r_state == S_TAIL))
        else $error("data byte pending outside a read");

    // A record byte on the output always belongs to a non-empty read.
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.has_data) |-> (o_result.count != '0))
        else $error("record byte with zero count");

    // The partial count never runs past the slot size.
    a_partial_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_partial <= LEN_W'(SLOT_BYTES))
        else $error("partial count beyond slot size");

    // A dropped record never has bytes of its own in progress.
    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> (r_partial == '0))
        else $error("dropping a record with bytes stored");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the record slot ring. Requests go in through the start/busy handshake;
// results come back on the strobe and cannot be held off. Every strobed result is
// checked field by field against the oldest prediction in a queue. The queue is filled
// at the edge where a request is taken, by a behavioral copy of the ring that keeps its
// own slot bytes, slot lengths, head and tail, full flag, partial record count and drop
// flag.
module tb_top;
    import rsrf_pkg::*;

    // The fourth request type has no meaning and must be ignored by the block.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Generous cycle limit. Each request is at most a 64-byte read plus a short gap, so a
    // correct run stays far below this.
    localparam int LIMIT_CYCLES = 200000;

    // Cycles allowed after the last expected result before configuration is touched or the
    // run ends. An ignored request causes no result, and a read drops busy in the cycle its
    // last byte shows, so a few cycles are plenty.
    localparam int SETTLE_CYCLES = 8;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_start     = 1'b0;
    t_req                 i_req       = '0;
    logic                 o_busy;
    logic                 o_strobe;
    t_result              o_result;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    record_slot_ring_fifo uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .o_busy      (o_busy),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------------------
    // Behavioral copy of the ring. Slot bytes are kept as 2-state values; the block's own
    // store is undefined until written, but a slot length only ever covers bytes that were
    // actually written, so no unwritten byte is ever compared.
    // ------------------------------------------------------------------------------------
    bit [7:0]       ring_bytes [NUM_SLOTS_DEF][SLOT_BYTES_DEF];
    bit [LEN_W-1:0] ring_len   [NUM_SLOTS_DEF];
    int unsigned    wr_slot    = 0;
    int unsigned    rd_slot    = 0;
    int unsigned    fill_count = 0;
    bit             ring_full  = 1'b0;
    bit             discarding = 1'b0;

    // Register copies, as written (raw); the clamping happens where they are used.
    int unsigned slot_size_cfg = 32'(RECORD_BYTES_RST);
    int unsigned slot_num_cfg  = 32'(SLOT_COUNT_RST);

    // Results still owed by the block, oldest first.
    t_result pending_results[$];

    int unsigned gap_pct     = 0;
    int unsigned err_count   = 0;
    int unsigned n_requests  = 0;
    int unsigned n_checked   = 0;
    int unsigned n_drops     = 0;
    int unsigned n_empty_rd  = 0;
    int unsigned n_full_hits = 0;
    int unsigned n_read_data = 0;
    int unsigned cycle_count = 0;

    // A record_bytes value outside 1..SLOT_BYTES is pulled back into range when used.
    function automatic int unsigned eff_size();
        if (slot_size_cfg < 1) return 1;
        if (slot_size_cfg > SLOT_BYTES_DEF) return SLOT_BYTES_DEF;
        return slot_size_cfg;
    endfunction

    // Same for slot_count against the number of physical slots.
    function automatic int unsigned eff_slots();
        if (slot_num_cfg < 1) return 1;
        if (slot_num_cfg > NUM_SLOTS_DEF) return NUM_SLOTS_DEF;
        return slot_num_cfg;
    endfunction

    // An index left at or past a lowered slot count wraps to slot 0 on its next step.
    function automatic int unsigned next_slot(input int unsigned idx);
        return (idx + 1 >= eff_slots()) ? 0 : idx + 1;
    endfunction

    function automatic bit ring_is_empty();
        return !ring_full && (wr_slot == rd_slot);
    endfunction

    // The empty and full flags of a result reflect the ring after the request has acted,
    // so this is only called once the state has been updated.
    function automatic void queue_result(input logic [7:0] data, input logic has,
                                         input logic last, input int unsigned cnt,
                                         input logic [1:0] st);
        t_result res;
        res.out_byte = data;
        res.has_data = has;
        res.out_last = last;
        res.count    = LEN_W'(cnt);
        res.status   = st;
        res.is_empty = ring_is_empty();
        res.is_full  = ring_full;
        if (ring_full) n_full_hits++;
        pending_results.push_back(res);
    endfunction

    // Works out the results one accepted request causes and moves the ring along.
    function automatic void predict_ring_results(input t_req r);
        int unsigned take;
        int unsigned cnt;
        int unsigned src;
        logic [1:0]  st;
        case (r.req_type)
            REQ_WRITE: begin
                st = ST_OK;
                // The full check is made only on a record's first byte, so a record that
                // is already under way is never cut off part way through.
                if (fill_count == 0 && !discarding && ring_full) discarding = 1'b1;
                if (discarding) begin
                    st  = ST_DROPPED;
                    cnt = 0;
                    n_drops++;
                    if (r.last_byte) discarding = 1'b0;
                end else begin
                    // Bytes past the slot size are thrown away, the count stays put.
                    if (fill_count < eff_size()) begin
                        ring_bytes[wr_slot][fill_count] = r.data_byte;
                        fill_count++;
                    end
                    cnt = fill_count;
                    if (r.last_byte) begin
                        ring_len[wr_slot] = LEN_W'(fill_count);
                        fill_count = 0;
                        wr_slot = next_slot(wr_slot);
                        if (wr_slot == rd_slot) ring_full = 1'b1;
                    end
                end
                queue_result(8'h00, 1'b0, 1'b1, cnt, st);
            end
            REQ_READ: begin
                if (ring_is_empty()) begin
                    n_empty_rd++;
                    queue_result(8'h00, 1'b0, 1'b1, 0, ST_EMPTY);
                end else begin
                    take = 32'(ring_len[rd_slot]);
                    if (32'(r.read_len) < take) take = 32'(r.read_len);
                    src = rd_slot;
                    // The slot is freed even when the reader asked for nothing.
                    ring_len[rd_slot] = '0;
                    rd_slot = next_slot(rd_slot);
                    ring_full = 1'b0;
                    if (take == 0) begin
                        queue_result(8'h00, 1'b0, 1'b1, 0, ST_OK);
                    end else begin
                        for (int i = 0; i < take; i++) begin
                            queue_result(ring_bytes[src][i], 1'b1, i == take - 1, take, ST_OK);
                        end
                        n_read_data += take;
                    end
                end
            end
            REQ_CLEAR: begin
                // Clear forgets lengths, pointers and any partial or dropped record; the
                // stored bytes themselves are left alone.
                foreach (ring_len[i]) ring_len[i] = '0;
                wr_slot    = 0;
                rd_slot    = 0;
                ring_full  = 1'b0;
                fill_count = 0;
                discarding = 1'b0;
                queue_result(8'h00, 1'b0, 1'b1, 0, ST_CLEARED);
            end
            default: begin
                // Unused request type: no result and no change of state.
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------------------
    // Result checking. Results are sampled at the edge that ends their cycle; the block
    // updates its outputs with nonblocking assignments, so the values seen here are the
    // ones that were on the ports during that cycle.
    // ------------------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("result strobed with no result pending (out_byte %0d, status %0d)",
                       o_result.out_byte, o_result.status);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("out_byte", want.out_byte, o_result.out_byte);
                compare_field("has_data", 8'(want.has_data), 8'(o_result.has_data));
                compare_field("out_last", 8'(want.out_last), 8'(o_result.out_last));
                compare_field("count",    8'(want.count),    8'(o_result.count));
                compare_field("status",   8'(want.status),   8'(o_result.status));
                compare_field("is_empty", 8'(want.is_empty), 8'(o_result.is_empty));
                compare_field("is_full",  8'(want.is_full),  8'(o_result.is_full));
                n_checked++;
            end
        end
    end

    // Hard stop in case the block hangs or stops producing results.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_results.size());
            $display("** record_slot_ring_fifo: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Request driving. Start stays high from one request to the next when no gap is drawn,
    // so back-to-back requests never lower and raise start in the same time step.
    // ------------------------------------------------------------------------------------
    function automatic t_req make_req(input logic [1:0] kind, input logic [7:0] data,
                                      input logic last, input logic [LEN_W-1:0] want_len);
        t_req r;
        r.req_type  = kind;
        r.data_byte = data;
        r.last_byte = last;
        r.read_len  = want_len;
        return r;
    endfunction

    task automatic issue_request(input t_req r);
        i_start <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_busy);
        predict_ring_results(r);
        if (r.req_type != REQ_UNUSED) n_requests++;
        if ($urandom_range(99) < gap_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Sends a whole record; fields that a write does not use still carry random values.
    task automatic write_record(input int unsigned nbytes);
        for (int i = 0; i < nbytes; i++) begin
            issue_request(make_req(REQ_WRITE, 8'($urandom_range(0, 255)), i == nbytes - 1,
                                   LEN_W'($urandom_range(0, 127))));
        end
    endtask

    task automatic read_oldest(input int unsigned want_len);
        issue_request(make_req(REQ_READ, 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)), LEN_W'(want_len)));
    endtask

    task automatic clear_ring();
        issue_request(make_req(REQ_CLEAR, 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)), LEN_W'($urandom_range(0, 127))));
    endtask

    // Holds the sender off until every predicted result has come back and the block has
    // had time to drop busy. Used before each configuration change and at random points.
    task automatic settle();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // Writes both registers one after the other; only called with the block idle.
    task automatic set_config(input int unsigned rec_bytes, input int unsigned slots);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_RECORD_BYTES;
        i_cfg_data  <= CFG_W'(rec_bytes);
        @(posedge i_clk);
        i_cfg_index <= CFG_SLOT_COUNT;
        i_cfg_data  <= CFG_W'(slots);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        slot_size_cfg = rec_bytes & 32'h7F;
        slot_num_cfg  = slots & 32'h1F;
    endtask

    // Mostly short records, now and then one that runs past the slot size.
    function automatic int unsigned pick_record_len();
        if ($urandom_range(9) == 0) return $urandom_range(1, eff_size() + 2);
        return $urandom_range(1, 6);
    endfunction

    // Read lengths cover zero, short reads that cut a record, the usual range and values
    // above the slot size that the 7-bit field still allows.
    function automatic int unsigned pick_read_len();
        case ($urandom_range(7))
            0:       return 0;
            1:       return $urandom_range(1, 3);
            2:       return $urandom_range(65, 127);
            default: return $urandom_range(0, 64);
        endcase
    endfunction

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // Default geometry: empty read, byte extremes, an ignored request type, a read asking
    // for more than is stored, a read of zero bytes that still frees its slot, a one-byte
    // read, and a clear that abandons a record in progress.
    task automatic test_basic_records();
        read_oldest(5);
        issue_request(make_req(REQ_WRITE, 8'hFF, 1'b0, 7'h00));
        issue_request(make_req(REQ_WRITE, 8'h00, 1'b0, 7'h7F));
        issue_request(make_req(REQ_WRITE, 8'hA5, 1'b1, 7'h00));
        issue_request(make_req(REQ_UNUSED, 8'hFF, 1'b1, 7'h7F));
        read_oldest(7'h7F);
        issue_request(make_req(REQ_WRITE, 8'h5A, 1'b1, 7'h40));
        issue_request(make_req(REQ_WRITE, 8'h3C, 1'b1, 7'h00));
        read_oldest(0);
        read_oldest(1);
        issue_request(make_req(REQ_WRITE, 8'h11, 1'b0, 7'h00));
        issue_request(make_req(REQ_WRITE, 8'h22, 1'b0, 7'h00));
        clear_ring();
        read_oldest(64);
    endtask

    // Two slots of two bytes: a record cut short, the ring filling, a whole record dropped
    // while full, and a read that makes room again.
    task automatic test_truncate_and_full();
        settle();
        set_config(2, 2);
        write_record(3);
        write_record(1);
        write_record(2);
        read_oldest(64);
        clear_ring();
    endtask

    // Zero in both registers behaves as one byte in one slot, so the first record fills
    // the ring at once.
    task automatic test_config_extremes();
        settle();
        set_config(0, 0);
        write_record(2);
        write_record(1);
        read_oldest(127);
    endtask

    // Well-formed records and reads with random content, with stray bytes, clears, ignored
    // requests and full pauses mixed in.
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = n_requests + n_items;
        while (n_requests < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                write_record(pick_record_len());
            end else if (pick < 80) begin
                read_oldest(pick_read_len());
            end else if (pick < 88) begin
                issue_request(make_req(REQ_WRITE, 8'($urandom_range(0, 255)), 1'b0,
                                       LEN_W'($urandom_range(0, 127))));
            end else if (pick < 92) begin
                clear_ring();
            end else if (pick < 95) begin
                issue_request(make_req(REQ_UNUSED, 8'($urandom_range(0, 255)),
                                       1'($urandom_range(0, 1)),
                                       LEN_W'($urandom_range(0, 127))));
            end else begin
                settle();
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First the sender gaps often.
        gap_pct = 29;
        test_basic_records();
        test_truncate_and_full();
        test_config_extremes();

        settle();
        set_config(64, 16);
        test_random_traffic(15);

        // Small slots and a ring of three, set while records may still be held, so the
        // pointers wrap from past the new slot count; full and drops become common.
        settle();
        set_config(5, 3);
        gap_pct = 54;
        test_random_traffic(15);

        // Out-of-range values clamp to the largest geometry; no gaps at all. A record longer
        // than a slot is followed by a read of the oldest record at the largest read length.
        settle();
        set_config(127, 31);
        gap_pct = 0;
        write_record(SLOT_BYTES_DEF + 2);
        read_oldest(127);
        test_random_traffic(15);

        settle();
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            err_count++;
        end

        $display("run covered %0d requests and %0d checked results, %0d of them read bytes",
                 n_requests, n_checked, n_read_data);
        $display("writes dropped on a full ring: %0d, reads of an empty ring: %0d, %s %0d",
                 n_drops, n_empty_rd, "results showing a full ring:", n_full_hits);
        if (err_count == 0) begin
            $display("** record_slot_ring_fifo: PASSED **");
        end else begin
            $display("** record_slot_ring_fifo: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rsrf_pkg.sv
hdl/rsrf_ram.sv
hdl/record_slot_ring_fifo.sv
bench/tb_top.sv
